>>> rtl/core/mecanum_drive_speed_controller_macros.svh
// assertion macros for the mecanum drive speed controller checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MECANUM_DRIVE_SPEED_CONTROLLER_MACROS_SVH
`define MECANUM_DRIVE_SPEED_CONTROLLER_MACROS_SVH

// same-cycle implication
`define MDSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mdsc assertion failed");

// next-cycle implication
`define MDSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mdsc assertion failed");

`endif

>>> rtl/core/mdsc_pkg.sv
// shared types, constants and helpers for the mecanum drive speed controller
// no dependencies
`default_nettype none

package mdsc_pkg;

  localparam int unsigned NumWheels         = 4;
  localparam int unsigned PwmMaxDefault     = 255;
  localparam int unsigned InvertMaskDefault = 5;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 22;

  localparam logic [20:0] SatCap    = 21'h100000;
  localparam logic [15:0] RpmScale  = 16'd60000;
  localparam logic [47:0] StepHalf  = 48'd1000 << 23;

  // integrator step divide by 1000: at or above 1000 * 2^20 the step saturates,
  // below it a reciprocal multiply is exact for 30-bit dividends
  localparam logic [37:0] StepBig     = 38'd1048576000;
  localparam logic [30:0] StepRecip   = 31'd1099511628;
  localparam int unsigned StepRecipSh = 40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEADBAND  = 4'd0,
    REG_PROP_GAIN = 4'd1,
    REG_INT_GAIN  = 4'd2,
    REG_FF_GAIN   = 4'd3,
    REG_INT_LIMIT = 4'd4,
    REG_MAX_RPM   = 4'd5,
    REG_CPR       = 4'd6,
    REG_LOOP_MASK = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DRV_FWD   = 2'd0,
    DRV_REV   = 2'd1,
    DRV_BRAKE = 2'd2
  } drive_e;

  typedef struct packed {
    logic [14:0] deadband;
    logic [23:0] prop_gain;
    logic [23:0] int_gain;
    logic [14:0] ff_gain;
    logic [14:0] int_limit;
    logic [11:0] max_rpm;
    logic [11:0] cpr;
    logic [3:0]  loop_mask;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    deadband:  15'd2621,
    prop_gain: 24'd46137,
    int_gain:  24'd167772,
    ff_gain:   15'd24576,
    int_limit: 15'd19661,
    max_rpm:   12'd220,
    cpr:       12'd44,
    loop_mask: 4'd0
  };

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] pwm;
    drive_e     drive;
  } lane_stat_t;

  // magnitude capped at 2^20
  function automatic logic [20:0] sat_cap(input logic [47:0] q);
    logic [20:0] r;
    if (q > 48'(SatCap)) r = SatCap;
    else r = q[20:0];
    return r;
  endfunction

  function automatic logic signed [22:0] apply_sign(input logic neg, input logic [21:0] m);
    logic signed [22:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mdsc_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on mdsc_pkg for widths
`default_nettype none

module mdsc_div
  import mdsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               go_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DivDenW-1:0] den_i,
  output logic                    done_o,
  output logic [DivNumW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, num_q[DivNumW-1]};
    if (go_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (run_q) begin
      // quotient bits shift in where numerator bits leave
      if (trial >= {1'b0, den_q}) begin
        rem_d = DivDenW'(trial - {1'b0, den_q});
        num_d = {num_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenW-1:0];
        num_d = {num_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

`default_nettype wire

>>> rtl/core/mdsc_lane.sv
// one wheel: normalize, deadband, open loop or feedforward plus PI, bridge output
// depends on mdsc_pkg and mdsc_div
`default_nettype none

module mdsc_lane
  import mdsc_pkg::*;
#(
  parameter int unsigned LaneIdx   = 0,
  parameter int unsigned PwmMax    = PwmMaxDefault,
  parameter logic        InvertBit = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire lane_ctrl_t         ctrl_i,
  input  wire logic signed [17:0] sum_i,
  input  wire logic [16:0]        max_i,
  input  wire logic signed [15:0] delta_i,
  input  wire logic [9:0]         dt_i,
  output lane_stat_t              stat_o
);

  localparam int unsigned PwmW     = $clog2(PwmMax + 1);
  localparam int unsigned PwmProdW = 17 + PwmW;
  localparam logic [7:0]  BrakePwm = 8'(PwmMax % 256);

  typedef enum logic [11:0] {
    L_IDLE   = 12'b000000000001,
    L_NDIV   = 12'b000000000010,
    L_DECIDE = 12'b000000000100,
    L_MMUL   = 12'b000000001000,
    L_MDIV   = 12'b000000010000,
    L_ERR    = 12'b000000100000,
    L_PMUL   = 12'b000001000000,
    L_SMUL   = 12'b000010000000,
    L_SDIV   = 12'b000100000000,
    L_STEP   = 12'b001000000000,
    L_SUM    = 12'b010000000000,
    L_DONE   = 12'b100000000000
  } lane_state_e;

  lane_state_e state_q, state_d;
  logic signed [16:0] integ_q, integ_d;
  logic               go_q, go_d;

  logic [DivNumW-1:0] dnum_q, dnum_d;
  logic [DivDenW-1:0] dden_q, dden_d;
  logic               div_done;
  logic [DivNumW-1:0] div_quo;

  logic        norm_neg_q, norm_neg_d;
  logic [16:0] norm_mag_q, norm_mag_d;
  logic        dlt_neg_q, dlt_neg_d;
  logic [15:0] dlt_mag_q, dlt_mag_d;
  logic [9:0]  dt_q, dt_d;
  logic [21:0] den_q, den_d;
  logic [31:0] mprod_q, mprod_d;
  logic [27:0] tgt_q, tgt_d;
  logic        err_neg_q, err_neg_d;
  logic [27:0] err_mag_q, err_mag_d;
  logic [51:0] pprod_q, pprod_d;
  logic [51:0] iprod_q, iprod_d;
  logic [61:0] sprod_q, sprod_d;
  logic [60:0] rprod_q, rprod_d;
  logic        step_big_q, step_big_d;
  logic [15:0] ff_mag_q, ff_mag_d;
  logic [20:0] p_mag_q, p_mag_d;
  logic [7:0]  pwm_q, pwm_d;
  drive_e      drv_q, drv_d;

  logic [16:0] s_mag;
  logic [11:0] cpr_fix;
  logic [9:0]  dt_fix;
  logic signed [29:0] tgt_s, meas_s, err_s;
  logic [20:0] meas_mag, step_mag;
  logic signed [22:0] step_s, acc, lim_s, sum_v;
  logic [63:0] snum;
  logic [37:0] snq;
  logic [52:0] pround;
  logic [30:0] ffprod;
  logic [9:0]  ol_out, cl_out;

  // clamp, deadband and direction for one wheel output
  function automatic logic [9:0] drive_out(input logic signed [22:0] v,
                                           input logic [14:0] db);
    logic signed [22:0] c;
    logic [15:0]        a;
    logic               fwd;
    logic [PwmProdW-1:0] prod;
    logic [9:0]         r;
    c = v;
    if (v > 23'sd32768) c = 23'sd32768;
    if (v < -23'sd32768) c = -23'sd32768;
    a = c[22] ? 16'(-c) : 16'(c);
    fwd = !c[22] ^ InvertBit;
    prod = PwmProdW'(PwmProdW'(a) * PwmProdW'(PwmMax)) + PwmProdW'(16384);
    if (a == 16'd0 || {1'b0, a} < {2'b0, db}) r = {BrakePwm, DRV_BRAKE};
    else r = {8'(prod >> 15), fwd ? DRV_FWD : DRV_REV};
    return r;
  endfunction

  mdsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .num_i  (dnum_q),
    .den_i  (dden_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    integ_d    = integ_q;
    go_d       = 1'b0;
    dnum_d     = dnum_q;
    dden_d     = dden_q;
    norm_neg_d = norm_neg_q;
    norm_mag_d = norm_mag_q;
    dlt_neg_d  = dlt_neg_q;
    dlt_mag_d  = dlt_mag_q;
    dt_d       = dt_q;
    den_d      = den_q;
    mprod_d    = mprod_q;
    tgt_d      = tgt_q;
    err_neg_d  = err_neg_q;
    err_mag_d  = err_mag_q;
    pprod_d    = pprod_q;
    iprod_d    = iprod_q;
    sprod_d    = sprod_q;
    rprod_d    = rprod_q;
    step_big_d = step_big_q;
    ff_mag_d   = ff_mag_q;
    p_mag_d    = p_mag_q;
    pwm_d      = pwm_q;
    drv_d      = drv_q;

    s_mag   = sum_i[17] ? 17'(-sum_i) : 17'(sum_i);
    cpr_fix = (cfg_i.cpr == 12'd0) ? 12'd1 : cfg_i.cpr;
    dt_fix  = (dt_i == 10'd0) ? 10'd1 : dt_i;
    tgt_s   = norm_neg_q ? -$signed({2'b0, tgt_q}) : $signed({2'b0, tgt_q});
    meas_mag = sat_cap(div_quo);
    meas_s  = dlt_neg_q ? -$signed({9'b0, meas_mag}) : $signed({9'b0, meas_mag});
    err_s   = tgt_s - meas_s;
    step_mag = step_big_q ? SatCap : 21'(rprod_q >> StepRecipSh);
    step_s  = apply_sign(err_neg_q, 22'(step_mag));
    acc     = 23'(integ_q) + step_s;
    lim_s   = $signed({8'b0, cfg_i.int_limit});
    sum_v   = apply_sign(norm_neg_q, 22'(ff_mag_q)) + apply_sign(err_neg_q, 22'(p_mag_q))
              + 23'(integ_q);
    snum    = 64'(sprod_q) + 64'(StepHalf);
    snq     = 38'(snum >> 24);
    pround  = 53'(pprod_q) + 53'(24'h800000);
    ffprod  = 31'(norm_mag_q) * 31'(cfg_i.ff_gain) + 31'd16384;
    ol_out  = drive_out(apply_sign(norm_neg_q, 22'(norm_mag_q)), cfg_i.deadband);
    cl_out  = drive_out(sum_v, cfg_i.deadband);

    case (state_q)
      L_IDLE: begin
        if (ctrl_i.start) begin
          norm_neg_d = sum_i[17];
          dlt_neg_d  = delta_i[15];
          dlt_mag_d  = delta_i[15] ? 16'(-delta_i) : 16'(delta_i);
          dt_d       = dt_fix;
          den_d      = 22'(cpr_fix) * 22'(dt_fix);
          if (max_i > 17'd32768) begin
            dnum_d  = {16'b0, s_mag, 15'b0} + 48'(max_i >> 1);
            dden_d  = 22'(max_i);
            go_d    = 1'b1;
            state_d = L_NDIV;
          end else begin
            norm_mag_d = s_mag;
            state_d    = L_DECIDE;
          end
        end
      end
      L_NDIV: begin
        if (div_done) begin
          norm_mag_d = div_quo[16:0];
          state_d    = L_DECIDE;
        end
      end
      L_DECIDE: begin
        if (norm_mag_q < {2'b0, cfg_i.deadband}) begin
          integ_d = '0;
          pwm_d   = BrakePwm;
          drv_d   = DRV_BRAKE;
          state_d = L_DONE;
        end else if (!cfg_i.loop_mask[LaneIdx]) begin
          pwm_d   = ol_out[9:2];
          drv_d   = drive_e'(ol_out[1:0]);
          state_d = L_DONE;
        end else begin
          mprod_d = 32'(dlt_mag_q) * 32'(RpmScale);
          state_d = L_MMUL;
        end
      end
      L_MMUL: begin
        // measured rpm in Q15: counts * 60000 * 2^15 / (cpr * dt)
        dnum_d  = {1'b0, mprod_q, 15'b0} + 48'(den_q >> 1);
        dden_d  = den_q;
        go_d    = 1'b1;
        tgt_d   = 28'(norm_mag_q) * 28'(cfg_i.max_rpm);
        state_d = L_MDIV;
      end
      L_MDIV: begin
        if (div_done) begin
          err_neg_d = err_s[29];
          err_mag_d = err_s[29] ? 28'(-err_s) : 28'(err_s);
          state_d   = L_ERR;
        end
      end
      L_ERR: begin
        pprod_d  = 52'(err_mag_q) * 52'(cfg_i.prop_gain);
        ff_mag_d = 16'(ffprod >> 15);
        state_d  = L_PMUL;
      end
      L_PMUL: begin
        iprod_d = 52'(err_mag_q) * 52'(cfg_i.int_gain);
        p_mag_d = sat_cap(48'(pround >> 24));
        state_d = L_SMUL;
      end
      L_SMUL: begin
        sprod_d = 62'(iprod_q) * 62'(dt_q);
        state_d = L_SDIV;
      end
      L_SDIV: begin
        // divide by 1000 through the reciprocal, saturating large dividends
        rprod_d    = 61'(snq[29:0]) * 61'(StepRecip);
        step_big_d = (snq >= StepBig);
        state_d    = L_STEP;
      end
      L_STEP: begin
        if (acc > lim_s) integ_d = 17'(lim_s);
        else if (acc < -lim_s) integ_d = 17'(-lim_s);
        else integ_d = 17'(acc);
        state_d = L_SUM;
      end
      L_SUM: begin
        pwm_d   = cl_out[9:2];
        drv_d   = drive_e'(cl_out[1:0]);
        state_d = L_DONE;
      end
      L_DONE: begin
        if (ctrl_i.ack) begin
          state_d = L_IDLE;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      integ_q <= '0;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      integ_q <= integ_d;
      go_q    <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dnum_q     <= dnum_d;
    dden_q     <= dden_d;
    norm_neg_q <= norm_neg_d;
    norm_mag_q <= norm_mag_d;
    dlt_neg_q  <= dlt_neg_d;
    dlt_mag_q  <= dlt_mag_d;
    dt_q       <= dt_d;
    den_q      <= den_d;
    mprod_q    <= mprod_d;
    tgt_q      <= tgt_d;
    err_neg_q  <= err_neg_d;
    err_mag_q  <= err_mag_d;
    pprod_q    <= pprod_d;
    iprod_q    <= iprod_d;
    sprod_q    <= sprod_d;
    rprod_q    <= rprod_d;
    step_big_q <= step_big_d;
    ff_mag_q   <= ff_mag_d;
    p_mag_q    <= p_mag_d;
    pwm_q      <= pwm_d;
    drv_q      <= drv_d;
  end

  assign stat_o.done  = (state_q == L_DONE);
  assign stat_o.pwm   = pwm_q;
  assign stat_o.drive = drv_q;

endmodule

`default_nettype wire

>>> rtl/core/mecanum_drive_speed_controller.sv
// Mecanum wheel-speed controller: one item per control tick carries the body command
// (x, y, omega in Q1.15), the tick length in ms and four encoder deltas, and yields one
// item with a PWM duty and bridge mode per wheel. Four wheel lanes run side by side, each
// with its own multiplier chain and a bit-serial divider; an open-loop or deadband wheel
// uses the divider only when the wheel norms need scaling, and a closed-loop wheel makes
// up to two passes through the lane divider (normalize, measured rpm). A stalled result
// delays the merge of the next. One item is in work at a time; a finished result waits
// in the output register while the next item is taken. Configuration writes are always
// ready and also reach an item that is already in work, as well as later items.
// depends on mdsc_pkg and mdsc_lane
`default_nettype none

module mecanum_drive_speed_controller
  import mdsc_pkg::*;
#(
  parameter int unsigned PwmMax     = PwmMaxDefault,
  parameter logic [3:0]  InvertMask = 4'(InvertMaskDefault)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [15:0]  cmd_x_i,
  input  wire logic signed [15:0]  cmd_y_i,
  input  wire logic signed [15:0]  cmd_omega_i,
  input  wire logic [9:0]          dt_ms_i,
  input  wire logic signed [15:0]  delta_fl_i,
  input  wire logic signed [15:0]  delta_fr_i,
  input  wire logic signed [15:0]  delta_rl_i,
  input  wire logic signed [15:0]  delta_rr_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               pwm_fl_o,
  output logic [1:0]               drive_fl_o,
  output logic [7:0]               pwm_fr_o,
  output logic [1:0]               drive_fr_o,
  output logic [7:0]               pwm_rl_o,
  output logic [1:0]               drive_rl_o,
  output logic [7:0]               pwm_rr_o,
  output logic [1:0]               drive_rr_o
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_MIX  = 3'b010,
    T_RUN  = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;
  cfg_t       cfg_q, cfg_d;
  logic       out_valid_q, out_valid_d;

  logic signed [15:0] x_q, y_q, w_q;
  logic [9:0]         dt_q;
  logic signed [15:0] dlt_q [NumWheels];
  logic [7:0]         opwm_q [NumWheels];
  drive_e             odrv_q [NumWheels];

  logic signed [17:0] sum [NumWheels];
  logic [16:0]        smag [NumWheels];
  logic [16:0]        mx01, mx23, mx;
  lane_ctrl_t         ctrl;
  lane_stat_t         stat [NumWheels];
  logic               all_done, merge, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && (state_q == T_IDLE);
  assign in_stall_o  = (state_q != T_IDLE);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEADBAND:  cfg_d.deadband  = cfg_data_i[14:0];
        REG_PROP_GAIN: cfg_d.prop_gain = cfg_data_i[23:0];
        REG_INT_GAIN:  cfg_d.int_gain  = cfg_data_i[23:0];
        REG_FF_GAIN:   cfg_d.ff_gain   = cfg_data_i[14:0];
        REG_INT_LIMIT: cfg_d.int_limit = cfg_data_i[14:0];
        REG_MAX_RPM:   cfg_d.max_rpm   = cfg_data_i[11:0];
        REG_CPR:       cfg_d.cpr       = cfg_data_i[11:0];
        REG_LOOP_MASK: cfg_d.loop_mask = cfg_data_i[3:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // wheel mixing: FL y+x+w, FR y-x-w, RL y-x+w, RR y+x-w
  always_comb begin
    sum[0] = 18'(y_q) + 18'(x_q) + 18'(w_q);
    sum[1] = 18'(y_q) - 18'(x_q) - 18'(w_q);
    sum[2] = 18'(y_q) - 18'(x_q) + 18'(w_q);
    sum[3] = 18'(y_q) + 18'(x_q) - 18'(w_q);
    for (int i = 0; i < NumWheels; i++) begin
      smag[i] = sum[i][17] ? 17'(-sum[i]) : 17'(sum[i]);
    end
    mx01 = (smag[0] > smag[1]) ? smag[0] : smag[1];
    mx23 = (smag[2] > smag[3]) ? smag[2] : smag[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NumWheels; i++) begin
      all_done = all_done && stat[i].done;
    end
  end

  assign merge      = (state_q == T_RUN) && all_done && (!out_valid_q || !out_stall_i);
  assign ctrl.start = (state_q == T_MIX);
  assign ctrl.ack   = merge;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) state_d = T_MIX;
      end
      T_MIX: begin
        state_d = T_RUN;
      end
      T_RUN: begin
        if (merge) begin
          out_valid_d = 1'b1;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < NumWheels; g++) begin : g_lane
    mdsc_lane #(
      .LaneIdx   (g),
      .PwmMax    (PwmMax),
      .InvertBit (InvertMask[g])
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .ctrl_i  (ctrl),
      .sum_i   (sum[g]),
      .max_i   (mx),
      .delta_i (dlt_q[g]),
      .dt_i    (dt_q),
      .stat_o  (stat[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= cmd_x_i;
      y_q      <= cmd_y_i;
      w_q      <= cmd_omega_i;
      dt_q     <= dt_ms_i;
      dlt_q[0] <= delta_fl_i;
      dlt_q[1] <= delta_fr_i;
      dlt_q[2] <= delta_rl_i;
      dlt_q[3] <= delta_rr_i;
    end
    if (merge) begin
      for (int i = 0; i < NumWheels; i++) begin
        opwm_q[i] <= stat[i].pwm;
        odrv_q[i] <= stat[i].drive;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_fl_o    = opwm_q[0];
  assign drive_fl_o  = odrv_q[0];
  assign pwm_fr_o    = opwm_q[1];
  assign drive_fr_o  = odrv_q[1];
  assign pwm_rl_o    = opwm_q[2];
  assign drive_rl_o  = odrv_q[2];
  assign pwm_rr_o    = opwm_q[3];
  assign drive_rr_o  = odrv_q[3];

endmodule

`default_nettype wire

>>> rtl/core/mdsc_checker.sv
// port-level checks for the mecanum drive speed controller, bound to the top level
// depends on mdsc_pkg and the assertion macro header
`default_nettype none

`include "mecanum_drive_speed_controller_macros.svh"

module mdsc_checker
  import mdsc_pkg::*;
#(
  parameter int unsigned PwmMax = PwmMaxDefault
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [7:0]          pwm_fl_o,
  input wire logic [1:0]          drive_fl_o,
  input wire logic [7:0]          pwm_rr_o,
  input wire logic [1:0]          drive_rr_o
);

  localparam logic [7:0] BrakePwm = 8'(PwmMax % 256);

  // a stalled result stays put
  `MDSC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pwm_fl_o))
  // one item in work at a time
  `MDSC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // braking wheels show the full duty
  `MDSC_ASSERT_IMP(a_brake_fl, out_valid_o && drive_fl_o == DRV_BRAKE, pwm_fl_o == BrakePwm)
  `MDSC_ASSERT_IMP(a_brake_rr, out_valid_o && drive_rr_o == DRV_BRAKE, pwm_rr_o == BrakePwm)
  // configuration writes are never held off
  `MDSC_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind mecanum_drive_speed_controller mdsc_checker #(.PwmMax(PwmMax)) u_mdsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pwm_fl_o    (pwm_fl_o),
  .drive_fl_o  (drive_fl_o),
  .pwm_rr_o    (pwm_rr_o),
  .drive_rr_o  (drive_rr_o)
);

`default_nettype wire

>>> tb/mecanum_drive_speed_controller_checker.sv
// checker for the mecanum drive speed controller: watches the config, input and output
// channels, predicts each output item from its own wheel model and compares field by field
// depends on mdsc_pkg
`default_nettype none

module mecanum_drive_speed_controller_checker
  import mdsc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic signed [15:0]  cmd_x_i,
  input  wire logic signed [15:0]  cmd_y_i,
  input  wire logic signed [15:0]  cmd_omega_i,
  input  wire logic [9:0]          dt_ms_i,
  input  wire logic signed [15:0]  delta_fl_i,
  input  wire logic signed [15:0]  delta_fr_i,
  input  wire logic signed [15:0]  delta_rl_i,
  input  wire logic signed [15:0]  delta_rr_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [3:0][7:0]     pwm_i,
  input  wire logic [3:0][1:0]     drive_i,
  output int                       failures_o,
  output int                       pending_o
);

  localparam longint unsigned OneQ15 = 64'd32768;
  localparam longint unsigned Cap    = 64'd1 << 20;

  typedef struct packed {
    logic [3:0][7:0] pwm;
    logic [3:0][1:0] drive;
  } wheel_cmds_t;

  cfg_t        cfg;
  longint      integ [4];
  wheel_cmds_t wheel_q[$];
  int          fails;

  assign failures_o = fails;
  assign pending_o  = wheel_q.size();

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // round(a*b/den) half away from zero, capped at 2^20
  function automatic longint unsigned scaled_round(input longint unsigned a,
      input longint unsigned b, input longint unsigned den);
    longint unsigned q;
    if (a != 0 && b > (64'hFFFF_FFFF_FFFF_FFFF - den) / a) return Cap;
    q = (a * b + den / 2) / den;
    return q > Cap ? Cap : q;
  endfunction

  function automatic longint signed_scaled(input longint v, input longint unsigned k,
      input longint unsigned den);
    longint unsigned q;
    q = scaled_round(abs64(v), k, den);
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void wheel_output(input int i, input longint v,
      inout wheel_cmds_t r);
    longint unsigned a;
    logic fwd;
    if (v > longint'(OneQ15)) v = OneQ15;
    if (v < -longint'(OneQ15)) v = -longint'(OneQ15);
    a = abs64(v);
    if (v == 0 || a < cfg.deadband) begin
      r.pwm[i]   = 8'(PwmMaxDefault);
      r.drive[i] = DRV_BRAKE;
    end else begin
      fwd = (v > 0) ^ InvertMaskDefault[i];
      r.pwm[i]   = 8'((a * PwmMaxDefault + OneQ15 / 2) / OneQ15);
      r.drive[i] = fwd ? DRV_FWD : DRV_REV;
    end
  endfunction

  function automatic wheel_cmds_t control_tick();
    wheel_cmds_t r;
    longint s [4];
    longint d [4];
    longint unsigned m, dt, cpr, q;
    longint nrm, meas, err, p, stp, ff, acc, lim;
    longint x, y, w;
    x = cmd_x_i; y = cmd_y_i; w = cmd_omega_i;
    d[0] = delta_fl_i; d[1] = delta_fr_i; d[2] = delta_rl_i; d[3] = delta_rr_i;
    dt  = dt_ms_i == 0 ? 1 : dt_ms_i;
    cpr = cfg.cpr == 0 ? 1 : cfg.cpr;
    s[0] = y + x + w;
    s[1] = y - x - w;
    s[2] = y - x + w;
    s[3] = y + x - w;
    m = 0;
    for (int i = 0; i < 4; i++) if (abs64(s[i]) > m) m = abs64(s[i]);
    for (int i = 0; i < 4; i++) begin
      nrm = s[i];
      if (m > OneQ15) begin
        q = (abs64(nrm) * OneQ15 + m / 2) / m;
        nrm = nrm < 0 ? -longint'(q) : longint'(q);
      end
      if (abs64(nrm) < cfg.deadband) begin
        integ[i]   = 0;
        r.pwm[i]   = 8'(PwmMaxDefault);
        r.drive[i] = DRV_BRAKE;
      end else if (!cfg.loop_mask[i]) begin
        wheel_output(i, nrm, r);
      end else begin
        meas = signed_scaled(d[i], 64'd60000 * OneQ15, cpr * dt);
        err  = nrm * longint'(cfg.max_rpm) - meas;
        lim  = cfg.int_limit;
        p    = signed_scaled(err, cfg.prop_gain, 64'd1 << 24);
        stp  = signed_scaled(err, cfg.int_gain * dt, (64'd1 << 24) * 1000);
        ff   = signed_scaled(nrm, cfg.ff_gain, OneQ15);
        acc  = integ[i] + stp;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ[i] = acc;
        wheel_output(i, ff + p + acc, r);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_cmds_t exp_cmd;
    if (!rst_ni) begin
      cfg = CfgReset;
      for (int i = 0; i < 4; i++) integ[i] = 0;
      wheel_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEADBAND:  cfg.deadband  = cfg_data_i[14:0];
          REG_PROP_GAIN: cfg.prop_gain = cfg_data_i[23:0];
          REG_INT_GAIN:  cfg.int_gain  = cfg_data_i[23:0];
          REG_FF_GAIN:   cfg.ff_gain   = cfg_data_i[14:0];
          REG_INT_LIMIT: cfg.int_limit = cfg_data_i[14:0];
          REG_MAX_RPM:   cfg.max_rpm   = cfg_data_i[11:0];
          REG_CPR:       cfg.cpr       = cfg_data_i[11:0];
          REG_LOOP_MASK: cfg.loop_mask = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) wheel_q.push_back(control_tick());
      if (out_valid_i && !out_stall_i) begin
        if (wheel_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected output item", $time);
        end else begin
          exp_cmd = wheel_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (pwm_i[i] !== exp_cmd.pwm[i]) begin
              fails++;
              $display("%0t: wheel %0d pwm expected %0d actual %0d", $time, i,
                       exp_cmd.pwm[i], pwm_i[i]);
            end
            if (drive_i[i] !== exp_cmd.drive[i]) begin
              fails++;
              $display("%0t: wheel %0d drive expected %0d actual %0d", $time, i,
                       exp_cmd.drive[i], drive_i[i]);
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/mecanum_drive_speed_controller_tb.sv
// testbench top for the mecanum drive speed controller: drives config, control ticks
// and output stalls, and reports the verdict from the checker's failure count
// depends on mdsc_pkg, mecanum_drive_speed_controller, mecanum_drive_speed_controller_checker
`default_nettype none

module mecanum_drive_speed_controller_tb;
  import mdsc_pkg::*;

  typedef struct packed {
    logic signed [15:0] x, y, w;
    logic [9:0]         dt;
    logic signed [15:0] dfl, dfr, drl, drr;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  logic in_stall;
  tick_t tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0][7:0] pwm;
  logic [3:0][1:0] drive;
  int failures, pending, burst_left;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  mecanum_drive_speed_controller uut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_x_i(tick.x), .cmd_y_i(tick.y), .cmd_omega_i(tick.w), .dt_ms_i(tick.dt),
    .delta_fl_i(tick.dfl), .delta_fr_i(tick.dfr),
    .delta_rl_i(tick.drl), .delta_rr_i(tick.drr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pwm_fl_o(pwm[0]), .drive_fl_o(drive[0]), .pwm_fr_o(pwm[1]), .drive_fr_o(drive[1]),
    .pwm_rl_o(pwm[2]), .drive_rl_o(drive[2]), .pwm_rr_o(pwm[3]), .drive_rr_o(drive[3])
  );

  mecanum_drive_speed_controller_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_x_i(tick.x), .cmd_y_i(tick.y), .cmd_omega_i(tick.w), .dt_ms_i(tick.dt),
    .delta_fl_i(tick.dfl), .delta_fr_i(tick.dfr),
    .delta_rl_i(tick.drl), .delta_rr_i(tick.drr),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pwm_i(pwm), .drive_i(drive),
    .failures_o(failures), .pending_o(pending)
  );

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // drain everything, then let an in-flight tick settle before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    // let the checker record the last accepted item first
    @(posedge clk_i);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [14:0] db, input logic [23:0] kp, input logic [23:0] ki,
      input logic [14:0] kff, input logic [14:0] lim, input logic [11:0] rpm,
      input logic [11:0] cpr, input logic [3:0] mask);
    settle();
    reg_write(REG_DEADBAND, 24'(db));
    reg_write(REG_PROP_GAIN, kp);
    reg_write(REG_INT_GAIN, ki);
    reg_write(REG_FF_GAIN, 24'(kff));
    reg_write(REG_INT_LIMIT, 24'(lim));
    reg_write(REG_MAX_RPM, 24'(rpm));
    reg_write(REG_CPR, 24'(cpr));
    reg_write(REG_LOOP_MASK, 24'(mask));
  endtask

  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic tick_t mk(input int x, input int y, input int w, input int dt,
      input int fl, input int fr, input int rl, input int rr);
    tick_t t;
    t.x = 16'(x); t.y = 16'(y); t.w = 16'(w); t.dt = 10'(dt);
    t.dfl = 16'(fl); t.dfr = 16'(fr); t.drl = 16'(rl); t.drr = 16'(rr);
    return t;
  endfunction

  function automatic logic [15:0] rand_cmd();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8000)) - 4000);
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.x = rand_cmd(); t.y = rand_cmd(); t.w = rand_cmd();
    case ($urandom_range(0, 4))
      0: t.dt = 10'($urandom);
      1: t.dt = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: t.dt = 10'($urandom_range(15, 25));
    endcase
    t.dfl = rand_delta(); t.dfr = rand_delta(); t.drl = rand_delta(); t.drr = rand_delta();
    return t;
  endfunction

  task automatic directed_ticks();
    send_tick(mk(0, 0, 0, 20, 0, 0, 0, 0));
    send_tick(mk(32767, 0, 0, 20, 100, -100, -100, 100));
    send_tick(mk(-32768, 0, 0, 20, -32768, 32767, 32767, -32768));
    send_tick(mk(0, 32767, 0, 1, 10, 10, 10, 10));
    send_tick(mk(0, -32768, 0, 1023, -10, -10, -10, -10));
    send_tick(mk(0, 0, 32767, 20, 0, 0, 0, 0));
    send_tick(mk(0, 0, -32768, 20, 5, 5, 5, 5));
    send_tick(mk(32767, 32767, 32767, 0, 32767, 32767, 32767, 32767));
    send_tick(mk(-32768, -32768, -32768, 20, -32768, -32768, -32768, -32768));
    send_tick(mk(-32768, 32767, 0, 20, 0, 1, -1, 0));
    send_tick(mk(1000, 1000, 0, 20, 3, 3, 3, 3));
    send_tick(mk(0, 2620, 0, 20, 0, 0, 0, 0));
    send_tick(mk(0, 2621, 0, 20, 0, 0, 0, 0));
    send_tick(mk(12000, -9000, 4000, 20, 30, -20, 10, -40));
  endtask

  task automatic random_ticks(input int n);
    repeat (n) send_tick(rand_tick());
  endtask

  // output stall in changing patterns, with one long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_done <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  initial begin
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_ticks();
    random_ticks(80);
    write_all(15'd2621, 24'd46137, 24'd167772, 15'd24576, 15'd19661, 12'd220, 12'd44,
              4'hF);
    directed_ticks();
    hold_req <= 1'b1;
    random_ticks(150);
    write_all(15'd0, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF, 15'd1, 12'd4095, 12'd1, 4'hF);
    random_ticks(80);
    // zero cpr and rpm, full deadband, upper bits dropped by the register width
    write_all(15'h7FFF, 24'd0, 24'd0, 15'd0, 15'h7FFF, 12'd0, 12'd0, 4'hA);
    reg_write(REG_DEADBAND, 24'hFF8000);
    reg_write(CfgIdxW'(REG_LOOP_MASK) + 4'd1, 24'd123);
    random_ticks(60);
    settle();
    reg_write(REG_DEADBAND, 24'd32767);
    random_ticks(70);
    repeat (6) begin
      write_all(15'($urandom_range(0, 6000)), 24'($urandom_range(0, 400000)),
                24'($urandom_range(0, 2000000)), 15'($urandom), 15'($urandom_range(1, 32767)),
                12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 4'($urandom));
      random_ticks(80);
    end
    settle();
    wait (hold_done);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
